@@ rtl/core/fpba_pkg.sv @@
// Shared types, constants and codes for the fit-policy partition allocator.
package fpba_pkg;

    localparam int NUM_PARTS   = 8;
    localparam int REG_COUNT   = 8;
    localparam int REG_IDX_W   = 3;
    localparam int IDX_W       = (NUM_PARTS > 1) ? $clog2(NUM_PARTS) : 1;
    localparam int SIZE_W      = 16;
    localparam int APB_ADDR_W  = REG_IDX_W + 2;
    localparam int APB_DATA_W  = 32;

    typedef enum logic [1:0] {
        FUNC_FIRST = 2'd0,
        FUNC_BEST  = 2'd1,
        FUNC_WORST = 2'd2,
        FUNC_BAD   = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_NOFIT   = 2'd1,
        STAT_BADFUNC = 2'd2
    } stat_t;

    typedef struct packed {
        logic [1:0]        func;
        logic [SIZE_W-1:0] request_size;
    } req_t;

    typedef struct packed {
        logic [1:0] status;
        logic [2:0] part_index;
    } rsp_t;

    typedef struct packed {
        logic [REG_IDX_W-1:0] idx;
        logic [SIZE_W-1:0]    data;
        logic                 wr;
    } cfg_wr_t;

    // controller -> datapath
    typedef struct packed {
        logic             load;
        logic             scan;
        logic [IDX_W-1:0] scan_idx;
        logic             commit;
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic bad_func;
        logic hit;
    } dp_sts_t;

endpackage

@@ rtl/core/fit_policy_block_allocator_core.sv @@
// Top level of the fit-policy partition allocator: APB decode, controller, datapath.
// Sequence: the accepting edge moves to the scan, which walks the partitions in index order,
//   then the commit state raises done; an invalid strategy skips the scan and goes to commit.
// Flow: a new request is taken only once the last one has finished; the scan runs one
//   partition per cycle through the single size read port; busy drops after done.
// Reset: rst_n clears all sizes to 0, marks every partition free, returns to idle.
// The result beat lasts one cycle with done high; the receiver cannot stall it.
module fit_policy_block_allocator_core
    import fpba_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  req_t                  req,
    output logic                  done,
    output rsp_t                  rsp,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    dp_cmd_t           cmd;
    dp_sts_t           sts;
    cfg_wr_t           cfg;
    logic [SIZE_W-1:0] rd_data;

    // APB: zero wait states; register i sits at byte address 4*i, the low
    // two address bits are ignored. Writes land in the access phase.
    assign pready   = 1'b1;
    assign cfg.wr   = psel && penable && pwrite;
    assign cfg.idx  = paddr[APB_ADDR_W-1:2];
    assign cfg.data = pwdata[SIZE_W-1:0];

    // Read-back shares the datapath read port; it is meaningful while idle.
    assign prdata = {{(APB_DATA_W - SIZE_W){1'b0}}, rd_data};

    fpba_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    fpba_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .cmd        (cmd),
        .cfg        (cfg),
        .cfg_rd_idx (paddr[APB_ADDR_W-1:2]),
        .rd_data    (rd_data),
        .sts        (sts),
        .rsp        (rsp)
    );

    // A result beat only ends a busy period, and lasts one cycle.
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("done without busy");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held longer than one cycle");

    // A new request starts only after the previous beat went out.
    a_idle_after_done: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy)
        else $error("busy after result beat");

    // Allocated results never point past the partition set.
    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        (done && rsp.status == STAT_OK) |-> (rsp.part_index <= 3'(NUM_PARTS - 1)))
        else $error("allocated index out of range");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (rsp.status == STAT_OK || rsp.status == STAT_NOFIT
                  || rsp.status == STAT_BADFUNC))
        else $error("undefined status code");

endmodule

@@ rtl/core/fpba_ctrl.sv @@
// Controller state machine: accept a request, sequence the partition scan, commit.
module fpba_ctrl
    import fpba_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  dp_sts_t sts,
    output dp_cmd_t cmd,
    output logic    busy,
    output logic    done
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } state_t;

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             accept;
    logic             last;

    assign accept = start && (state_reg == S_IDLE);
    assign last   = (idx_reg == IDX_W'(NUM_PARTS - 1));

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_SCAN;
                    idx_next   = '0;
                end
            end
            S_SCAN:
            begin
                // drop straight to the result on a bad strategy
                if (sts.bad_func || last)
                    state_next = S_DONE;
                else
                    idx_next = idx_reg + IDX_W'(1);
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    assign cmd.load     = accept;
    assign cmd.scan     = (state_reg == S_SCAN) && !sts.bad_func;
    assign cmd.scan_idx = idx_reg;
    assign cmd.commit   = (state_reg == S_DONE);

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_DONE);

endmodule

@@ rtl/core/fpba_dp.sv @@
// Datapath: size registers, allocated flags, compare-and-select over the scan.
module fpba_dp
    import fpba_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  req_t                 req,
    input  dp_cmd_t              cmd,
    input  cfg_wr_t              cfg,
    input  logic [REG_IDX_W-1:0] cfg_rd_idx,
    output logic [SIZE_W-1:0]    rd_data,
    output dp_sts_t              sts,
    output rsp_t                 rsp
);

    logic [SIZE_W-1:0]    size_reg [REG_COUNT];
    logic [NUM_PARTS-1:0] flag_reg;

    logic [1:0]           func_reg;
    logic [SIZE_W-1:0]    want_reg;
    logic                 found_reg, found_next;
    logic [IDX_W-1:0]     pick_reg, pick_next;
    logic [SIZE_W-1:0]    pick_size_reg, pick_size_next;

    logic [REG_IDX_W-1:0] rd_idx;
    logic                 fits;
    logic                 take;

    // one read port, shared by the scan and the register read-back
    assign rd_idx  = cmd.scan ? REG_IDX_W'(cmd.scan_idx) : cfg_rd_idx;
    assign rd_data = size_reg[rd_idx];

    assign fits = !flag_reg[cmd.scan_idx] && (rd_data >= want_reg);

    always_comb
    begin
        take = 1'b0;
        if (cmd.scan && fits)
        begin
            if (!found_reg)
                take = 1'b1;
            else
            begin
                case (func_reg)
                    FUNC_BEST:  take = (rd_data < pick_size_reg);
                    FUNC_WORST: take = (rd_data > pick_size_reg);
                    default:    take = 1'b0;
                endcase
            end
        end
    end

    always_comb
    begin
        found_next     = found_reg;
        pick_next      = pick_reg;
        pick_size_next = pick_size_reg;
        if (cmd.load)
            found_next = 1'b0;
        else if (take)
        begin
            found_next     = 1'b1;
            pick_next      = cmd.scan_idx;
            pick_size_next = rd_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < REG_COUNT; i++)
                size_reg[i] <= '0;
            flag_reg  <= '0;
            found_reg <= 1'b0;
        end
        else
        begin
            if (cfg.wr)
                size_reg[cfg.idx] <= cfg.data;
            if (cmd.commit && found_reg && (func_reg != FUNC_BAD))
                flag_reg[pick_reg] <= 1'b1;
            found_reg <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg <= req.func;
            want_reg <= req.request_size;
        end
        pick_reg      <= pick_next;
        pick_size_reg <= pick_size_next;
    end

    assign sts.bad_func = (func_reg == FUNC_BAD);
    assign sts.hit      = found_reg;

    always_comb
    begin
        rsp.part_index = '0;
        if (func_reg == FUNC_BAD)
            rsp.status = STAT_BADFUNC;
        else if (found_reg)
        begin
            rsp.status     = STAT_OK;
            rsp.part_index = 3'(pick_reg);
        end
        else
            rsp.status = STAT_NOFIT;
    end

endmodule

@@ verif/fit_policy_block_allocator_core_test.sv @@
// Self-checking testbench for the fit-policy partition allocator core.
module fit_policy_block_allocator_core_test;
    import fpba_pkg::*;

    // Stop after this many cycles in which no beat, result or register access is taken.
    localparam int STALL_LIMIT   = 4000;
    localparam int RANDOM_PHASES = 5;
    localparam int PHASE_ITEMS   = 180;

    // One queued request; drain makes the driver hold it until the block has gone quiet.
    typedef struct {
        req_t item;
        bit   drain;
    } alloc_request_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    req_t                  req = '0;
    logic                  done;
    rsp_t                  rsp;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // Shadow of the partition sizes and of the allocated flags.
    logic [SIZE_W-1:0] size_shadow [REG_COUNT];
    logic              part_taken  [NUM_PARTS];

    alloc_request_t request_backlog [$];
    rsp_t           expected_grants [$];
    rsp_t           expected_rsp;

    int fail_count   = 0;
    int gap_left     = 0;
    int burst_left   = 1;
    int stall_cycles = 0;

    fit_policy_block_allocator_core dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .req     (req),
        .done    (done),
        .rsp     (rsp),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #1 clk = ~clk;

    // Predict the grant for one accepted request and claim the partition it names.
    // Scan the in-range partitions in index order; a strict compare keeps the lower
    // index on equal sizes, and first fit never replaces its first candidate.
    function automatic rsp_t claim_partition(req_t r);
        rsp_t  grant;
        func_t strategy;
        int    pick;
        grant    = '0;
        strategy = func_t'(r.func);
        pick     = -1;
        if (strategy == FUNC_BAD)
        begin
            grant.status = STAT_BADFUNC;
        end
        else
        begin
            for (int i = 0; i < NUM_PARTS; i++)
            begin
                if (!part_taken[i] && size_shadow[i] >= r.request_size)
                begin
                    if (pick < 0)
                        pick = i;
                    else if (strategy == FUNC_BEST && size_shadow[i] < size_shadow[pick])
                        pick = i;
                    else if (strategy == FUNC_WORST && size_shadow[i] > size_shadow[pick])
                        pick = i;
                end
            end
            if (pick < 0)
            begin
                grant.status = STAT_NOFIT;
            end
            else
            begin
                part_taken[pick] = 1'b1;
                grant.status     = STAT_OK;
                grant.part_index = pick[2:0];
            end
        end
        return grant;
    endfunction

    // Draw a size that lands on the edges: zero, all ones, small values,
    // anything, or one step around a size that is configured now.
    function automatic logic [SIZE_W-1:0] edgy_size();
        logic [SIZE_W-1:0] value;
        logic [31:0]       raw;
        raw = $urandom;
        case ($urandom_range(0, 7))
            0:       value = '0;
            1:       value = '1;
            2, 3:    value = SIZE_W'($urandom_range(0, 15));
            4, 5:    value = raw[SIZE_W-1:0];
            default: value = size_shadow[$urandom_range(0, REG_COUNT-1)]
                             + SIZE_W'($urandom_range(0, 2)) - SIZE_W'(1);
        endcase
        return value;
    endfunction

    task automatic queue_request(input func_t strategy, input logic [SIZE_W-1:0] amount,
                                 input bit drain);
        alloc_request_t entry;
        entry.item.func         = strategy;
        entry.item.request_size = amount;
        entry.drain             = drain;
        request_backlog.push_back(entry);
    endtask

    // Wait on the falling edge, where every rising-edge update has settled,
    // until nothing is queued, in flight or still owed by the block.
    task automatic wait_idle();
        do
            @(negedge clk);
        while (request_backlog.size() != 0 || start || busy || done
               || expected_grants.size() != 0);
    endtask

    // Write one size register with junk in the upper data bits, then read it back.
    task automatic write_part_size(input int idx, input logic [SIZE_W-1:0] value);
        logic [15:0] junk;
        junk = 16'($urandom);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'(idx * 4);
        pwdata  <= {junk, value};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        size_shadow[idx] = value;
        // Turn the bus around straight into the read-back setup.
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata[SIZE_W-1:0] !== value)
        begin
            $display("%0t: part_size_%0d read back expected %0d actual %0d",
                     $time, idx, value, prdata[SIZE_W-1:0]);
            fail_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Driver: present one request beat at a time, in bursts with random gaps.
    // Pick the next beat only when the current one was taken or none was up, so
    // start never drops and rises again within one edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start      <= 1'b0;
            req        <= '0;
            gap_left   = 0;
            burst_left = 1;
        end
        else
        begin
            if (start && !busy)
                expected_grants.push_back(claim_partition(req));
            if (start && busy)
            begin
                // Hold the beat until the block takes it.
            end
            else if (gap_left > 0)
            begin
                gap_left--;
                start <= 1'b0;
            end
            else if (request_backlog.size() != 0
                     && (!request_backlog[0].drain
                         || (expected_grants.size() == 0 && !done && !busy)))
            begin
                req   <= request_backlog[0].item;
                start <= 1'b1;
                request_backlog.pop_front();
                burst_left--;
                if (burst_left <= 0)
                begin
                    burst_left = $urandom_range(1, 12);
                    // Leave a third of the bursts back to back.
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
                end
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: match each result beat against the oldest predicted grant.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_grants.size() == 0)
            begin
                $display("%0t: unexpected result expected none actual status %0d index %0d",
                         $time, rsp.status, rsp.part_index);
                fail_count++;
            end
            else
            begin
                expected_rsp = expected_grants.pop_front();
                if (rsp.status !== expected_rsp.status)
                begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, expected_rsp.status, rsp.status);
                    fail_count++;
                end
                if (rsp.part_index !== expected_rsp.part_index)
                begin
                    $display("%0t: part_index expected %0d actual %0d",
                             $time, expected_rsp.part_index, rsp.part_index);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: count cycles in which no beat, result or register access moves.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done || (psel && penable && pready))
        begin
            stall_cycles <= 0;
        end
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial
    begin
        for (int i = 0; i < REG_COUNT; i++)
            size_shadow[i] = '0;
        for (int i = 0; i < NUM_PARTS; i++)
            part_taken[i] = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Reset sizes are all zero: only a zero-size request can fit.
        @(negedge clk);
        queue_request(FUNC_BAD,   16'd0,     1'b0);
        queue_request(FUNC_FIRST, 16'd1,     1'b0);
        queue_request(FUNC_FIRST, 16'd0,     1'b0);
        queue_request(FUNC_BAD,   16'hFFFF,  1'b0);
        wait_idle();

        // Put a tie at the top size and a tie at 100 to check lower-index wins.
        write_part_size(0, 16'hFFFF);
        write_part_size(1, 16'd100);
        write_part_size(2, 16'd50);
        write_part_size(3, 16'd100);
        write_part_size(4, 16'hFFFF);
        write_part_size(5, 16'd0);
        write_part_size(6, 16'd50);
        write_part_size(7, 16'hFFFF);
        @(negedge clk);
        queue_request(FUNC_WORST, 16'hFFFF,  1'b0);
        queue_request(FUNC_BEST,  16'd60,    1'b0);
        queue_request(FUNC_FIRST, 16'hFFFF,  1'b0);
        queue_request(FUNC_FIRST, 16'hFFFF,  1'b0);
        queue_request(FUNC_BAD,   16'd1,     1'b0);
        wait_idle();

        // Grow a partition that is already taken: its flag must survive.
        write_part_size(1, 16'hFFFF);
        write_part_size(2, 16'd0);
        @(negedge clk);
        queue_request(FUNC_WORST, 16'hFFFF,  1'b0);
        queue_request(FUNC_BEST,  16'd0,     1'b0);
        wait_idle();

        // Random phases: fresh sizes, then mixed requests with occasional drains.
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            for (int i = 0; i < REG_COUNT; i++)
                write_part_size(i, edgy_size());
            @(negedge clk);
            for (int n = 0; n < PHASE_ITEMS; n++)
                queue_request(($urandom_range(0, 9) == 0) ? FUNC_BAD
                                                          : func_t'($urandom_range(0, 2)),
                              edgy_size(), $urandom_range(0, 39) == 0);
            wait_idle();
        end

        // Leave room for a stray result beat after the last grant.
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
